[design/assert_macros.svh]
// Assertion helpers for the checker file.
// Each macro builds one clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that ante implies cons on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that ante implies cons on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dbnc_lp_pkg.sv]
// ----------------------------------------------------------------------------
// dbnc_lp_pkg
// Types and constants shared by the debounce and long-press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dbnc_lp_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2,
        EV_LONG     = 2'd3
    } event_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_ms;
        logic [CFG_DATA_W-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        event_t event_code;
        logic   stable_level;
    } result_t;

endpackage

`default_nettype wire

[design/dbnc_lp_cfg.sv]
// ----------------------------------------------------------------------------
// dbnc_lp_cfg
// Configuration register file: debounce and long-press times.
// ----------------------------------------------------------------------------
`default_nettype none

module dbnc_lp_cfg
    import dbnc_lp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; drop writes to unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE:   cfg_next.debounce_ms   = wr_data;
                REG_LONG_PRESS: cfg_next.long_press_ms = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/dbnc_lp_eval.sv]
// ----------------------------------------------------------------------------
// dbnc_lp_eval
// Debounce state and event decision for one sample per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dbnc_lp_eval
    import dbnc_lp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic              level,
    input  wire logic [TIME_W-1:0] now,
    input  wire cfg_t              cfg,
    output result_t                res
);

    logic              prev_raw_reg;
    logic              prev_raw_next;
    logic              stable_reg;
    logic              stable_next;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] press_time_reg;
    logic [TIME_W-1:0] press_time_next;
    logic              long_reg;
    logic              long_next;

    logic              settled;
    logic              take;
    logic              long_base;
    logic              long_fire;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    event_t            ev;

    // Restart the debounce timer on any raw change, then judge the elapsed time
    always_comb
    begin
        change_time_next = (level != prev_raw_reg) ? now : change_time_reg;
        since_change     = now - change_time_next;
        settled          = since_change > TIME_W'(cfg.debounce_ms);
        take             = settled && (level != stable_reg);
        stable_next      = take ? level : stable_reg;
        press_time_next  = (take && level) ? now : press_time_reg;
        long_base        = (take && !level) ? 1'b0 : long_reg;
        since_press      = now - press_time_next;
        long_fire        = settled && !long_base && stable_next
                           && (since_press > TIME_W'(cfg.long_press_ms));
        long_next        = long_base | long_fire;
        prev_raw_next    = level;
    end

    // Pick the event: long press overrides press or release
    always_comb
    begin
        priority if (long_fire)
            ev = EV_LONG;
        else if (take && level)
            ev = EV_PRESSED;
        else if (take)
            ev = EV_RELEASED;
        else
            ev = EV_NONE;
    end

    // Advance state only when a sample is handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_reg        <= 1'b0;
        end
        else if (fire)
        begin
            prev_raw_reg    <= prev_raw_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            long_reg        <= long_next;
        end
    end

    assign res.event_code   = ev;
    assign res.stable_level = stable_next;

endmodule

`default_nettype wire

[design/debounce_press_longpress_detector.sv]
// ----------------------------------------------------------------------------
// Debounced push-button detector with press, release and long-press events.
//
// Input channel: raw_level and now_ms with in_valid / in_stall. A transfer
// takes place on a rising edge with in_valid high and in_stall low.
// Output channel: event_code and stable_level with out_valid / out_stall;
// exactly one result per input transfer, in order.
// Configuration: cfg_valid / cfg_ready write port, index 0 debounce_ms,
// index 1 long_press_ms; other indexes are ignored. cfg_ready is always high.
// Write configuration only while no item is in flight.
//
// Path: each sample is held in the input register, evaluated, and captured
// into the result register, which drives out_valid. Throughput: one item per
// cycle while out_stall is low; the eval state updates as each item moves from
// the input register to the result register.
// Reset: pipeline empty, debounced level low, timers at zero, registers at
// 50 ms and 1000 ms.
// Stall: a stalled result holds; the input register still takes one more
// item, after which in_stall follows out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module debounce_press_longpress_detector
    import dbnc_lp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic                  raw_level,
    input  wire logic [TIME_W-1:0]     now_ms,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [1:0]            event_code,
    output      logic                  stable_level,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    result_t           res;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;

    logic              advance;
    logic              fire;
    logic              in_take;

    assign cfg_ready = 1'b1;

    dbnc_lp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the result register moves when empty or drained
    always_comb
    begin
        advance        = !out_valid_reg || !out_stall;
        fire           = s1_valid_reg && advance;
        in_stall       = s1_valid_reg && !advance;
        in_take        = in_valid && !in_stall;
        s1_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    dbnc_lp_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .level (s1_level_reg),
        .now   (s1_now_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input sample
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_level_reg <= raw_level;
            s1_now_reg   <= now_ms;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_code   = out_res_reg.event_code;
    assign stable_level = out_res_reg.stable_level;

endmodule

`default_nettype wire

[design/dbnc_lp_checker.sv]
// ----------------------------------------------------------------------------
// dbnc_lp_checker
// Port-level checks for the debounce and long-press detector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dbnc_lp_checker
    import dbnc_lp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [1:0]            event_code,
    input wire logic                  stable_level
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
                 "out_valid dropped while stalled")

    // A stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
                 $stable(event_code) && $stable(stable_level),
                 "payload changed while stalled")

    // A press leaves the level high
    `ASSERT_IMPL(a_press_lvl, clk, rst_n, out_valid && (event_code == EV_PRESSED),
                 stable_level, "press with low level")

    // A release or long press agrees with the level
    `ASSERT_IMPL(a_rel_lvl, clk, rst_n, out_valid && (event_code == EV_RELEASED),
                 !stable_level, "release with high level")
    `ASSERT_IMPL(a_long_lvl, clk, rst_n, out_valid && (event_code == EV_LONG),
                 stable_level, "long press with low level")

endmodule

bind debounce_press_longpress_detector dbnc_lp_checker u_dbnc_lp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code),
    .stable_level (stable_level)
);

`default_nettype wire

[tb/sv/tb_debounce_press_longpress_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounce_press_longpress_detector
// Self-checking bench for the debounced button detector. A driver feeds pin
// samples with time stamps from a queue, a button model in the bench predicts
// the event and debounced level of each sample, and a monitor compares every
// result transfer against the oldest prediction. Both sides idle at random.
// The run steps through several debounce and long-press settings.
// ----------------------------------------------------------------------------

module tb_debounce_press_longpress_detector;

    import dbnc_lp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 220;
    localparam int unsigned CALM_FROM     = 500;
    localparam int unsigned CALM_TO       = 800;
    localparam int unsigned IDLE_PERCENT  = 17;
    localparam int unsigned REPORT_MAX    = 10;

    // Indexes outside the register file, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] stamp;
    } pin_sample_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  raw_level    = 1'b0;
    logic [TIME_W-1:0]     now_ms       = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [1:0]            event_code;
    logic                  stable_level;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    pin_sample_t           samples_q[$];
    result_t               button_events_q[$];
    logic [TIME_W-1:0]     clock_ms     = '0;
    int unsigned           queued_cnt   = 0;
    int unsigned           taken_cnt    = 0;
    int unsigned           fault_cnt    = 0;
    int unsigned           cycle_cnt    = 0;

    // Button model state and register mirror
    logic [CFG_DATA_W-1:0] want_debounce = DEBOUNCE_RST;
    logic [CFG_DATA_W-1:0] want_long     = LONG_PRESS_RST;
    logic                  seen_raw      = 1'b0;
    logic                  held_level    = 1'b0;
    logic [TIME_W-1:0]     edge_stamp    = '0;
    logic [TIME_W-1:0]     press_stamp   = '0;
    logic                  long_reported = 1'b0;

    debounce_press_longpress_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_level    (raw_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .stable_level (stable_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the button model by one pin sample and return its event
    function automatic result_t advance_button(input logic lvl, input logic [TIME_W-1:0] t);
        result_t           res;
        event_t            ev;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] since_press;
        ev = EV_NONE;
        if (lvl != seen_raw)
            edge_stamp = t;
        since_edge = t - edge_stamp;
        if (since_edge > TIME_W'(want_debounce))
        begin
            if (lvl != held_level)
            begin
                held_level = lvl;
                if (held_level)
                begin
                    press_stamp = t;
                    ev = EV_PRESSED;
                end
                else
                begin
                    long_reported = 1'b0;
                    ev = EV_RELEASED;
                end
            end
            since_press = t - press_stamp;
            if (!long_reported && held_level && since_press > TIME_W'(want_long))
            begin
                long_reported = 1'b1;
                ev = EV_LONG;
            end
        end
        seen_raw = lvl;
        res.event_code   = ev;
        res.stable_level = held_level;
        return res;
    endfunction

    // Idle at random, except in one calm stretch of transfers
    function automatic bit take_break();
        if (taken_cnt >= CALM_FROM && taken_cnt < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // Driver: predict each input transfer, then load the next sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            raw_level <= 1'b0;
            now_ms    <= '0;
        end
        else
        begin
            pin_sample_t nxt;
            if (in_valid && !in_stall)
            begin
                button_events_q.push_back(advance_button(raw_level, now_ms));
                taken_cnt <= taken_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (samples_q.size() != 0 && !take_break())
                begin
                    nxt = samples_q.pop_front();
                    in_valid  <= 1'b1;
                    raw_level <= nxt.level;
                    now_ms    <= nxt.stamp;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            result_t want;
            if (out_valid && !out_stall)
            begin
                if (button_events_q.size() == 0)
                begin
                    if (fault_cnt < REPORT_MAX)
                        $display("unexpected result: event_code %0d stable_level %0b",
                                 event_code, stable_level);
                    fault_cnt <= fault_cnt + 1;
                end
                else
                begin
                    want = button_events_q.pop_front();
                    if (event_code !== want.event_code || stable_level !== want.stable_level)
                    begin
                        if (fault_cnt < REPORT_MAX)
                            $display("mismatch: event exp %0d got %0d, level exp %0b got %0b",
                                     want.event_code, event_code,
                                     want.stable_level, stable_level);
                        fault_cnt <= fault_cnt + 1;
                    end
                end
            end
            out_stall <= take_break();
        end
    end

    // Write one register and mirror it once the transfer has happened
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_DEBOUNCE)
            want_debounce = val;
        else if (idx == REG_LONG_PRESS)
            want_long = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_at(input logic lvl, input logic [TIME_W-1:0] t);
        clock_ms = t;
        samples_q.push_back('{level: lvl, stamp: t});
        queued_cnt++;
    endtask

    task automatic queue_after(input logic lvl, input int unsigned dt);
        queue_at(lvl, clock_ms + TIME_W'(dt));
    endtask

    // Chatter towards a level, then settle on it
    task automatic queue_edge(input logic lvl, input int unsigned dbn);
        int unsigned flips;
        int unsigned settle;
        flips  = $urandom_range(0, 4);
        settle = $urandom_range(1, 3);
        repeat (2 * flips)
            queue_after(($urandom_range(0, 1) == 1) ? lvl : !lvl, $urandom_range(0, dbn));
        repeat (settle)
            queue_after(lvl, $urandom_range(0, dbn / 2 + 2));
    endtask

    // One press: bouncy leading edge, a hold of random length, bouncy release
    task automatic queue_press_cycle(input int unsigned dbn, input int unsigned lp);
        int unsigned holds;
        holds = $urandom_range(1, 6);
        queue_edge(1'b1, dbn);
        repeat (holds)
            queue_after(1'b1, $urandom_range(dbn / 2, lp / 2 + dbn + 2));
        queue_edge(1'b0, dbn);
        queue_after(1'b0, $urandom_range(0, dbn + 2));
    endtask

    // Noise: random levels, odd steps and time jumps, backwards ones included
    task automatic queue_noise(input int unsigned dbn);
        int unsigned cnt;
        cnt = $urandom_range(1, 5);
        repeat (cnt)
        begin
            case ($urandom_range(0, 3))
                0:       queue_at(1'($urandom_range(0, 1)), $urandom());
                1:       queue_after(1'($urandom_range(0, 1)), 0);
                default: queue_after(1'($urandom_range(0, 1)),
                                     $urandom_range(0, 2 * dbn + 2));
            endcase
        end
    endtask

    // Hold back until every prediction has been matched
    task automatic wait_drained();
        while (samples_q.size() != 0 || in_valid || button_events_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] dbn_set[6];
        logic [CFG_DATA_W-1:0] lp_set[6];
        int unsigned           goal;
        int unsigned           half;
        bit                    paused;

        dbn_set = '{16'd0, 16'hFFFF, CFG_DATA_W'($urandom_range(1, 40)),
                    CFG_DATA_W'($urandom_range(0, 200)), 16'hFFFF, 16'd1};
        lp_set  = '{16'd0, 16'hFFFF, CFG_DATA_W'($urandom_range(20, 300)),
                    CFG_DATA_W'($urandom_range(0, 3000)), 16'd0, 16'hFFFF};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: early times, exact thresholds, wrap and backwards time
        queue_at(1'b0, 32'h0000_0000);
        queue_at(1'b0, 32'h0000_0033);
        queue_at(1'b1, 32'h0000_003C);
        queue_at(1'b1, 32'h0000_006E);
        queue_at(1'b1, 32'h0000_006F);
        queue_at(1'b1, 32'h0000_0457);
        queue_at(1'b1, 32'h0000_0458);
        queue_at(1'b1, 32'h0000_1388);
        queue_at(1'b0, 32'h0000_1392);
        queue_at(1'b1, 32'h0000_139C);
        queue_at(1'b0, 32'h0000_13A6);
        queue_at(1'b0, 32'h0000_13D9);
        queue_at(1'b1, 32'hFFFF_FFC0);
        queue_at(1'b1, 32'h0000_0000);
        queue_at(1'b1, 32'hFFFF_FFFF);
        queue_at(1'b0, 32'h0000_0100);
        queue_at(1'b0, 32'h0000_0050);
        queue_at(1'b1, 32'hAAAA_AAAA);
        queue_at(1'b1, 32'h5555_5555);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 3)
            begin
                write_reg(REG_UNUSED, 16'hFFFF);
                write_reg(REG_TOP, 16'h0000);
            end
            write_reg(REG_DEBOUNCE, dbn_set[ph]);
            write_reg(REG_LONG_PRESS, lp_set[ph]);
            @(negedge clk);

            // Zero debounce: accept on the first step away from the edge time
            if (ph == 0)
            begin
                queue_at(1'b1, 32'd1000);
                queue_at(1'b1, 32'd1000);
                queue_at(1'b1, 32'd1001);
                queue_at(1'b1, 32'd1002);
                queue_at(1'b0, 32'd1003);
                queue_at(1'b0, 32'd1004);
            end

            // Start half the phases just short of the time wrap
            if (ph % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 262144));
            else
                clock_ms = $urandom();

            goal   = queued_cnt + PHASE_ITEMS;
            half   = queued_cnt + PHASE_ITEMS / 2;
            paused = 1'b0;
            while (queued_cnt < goal)
            begin
                if (ph == 2 && !paused && queued_cnt >= half)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 8)
                    queue_press_cycle(32'(dbn_set[ph]), 32'(lp_set[ph]));
                else
                    queue_noise(32'(dbn_set[ph]));
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fault_cnt == 0 && button_events_q.size() == 0)
            $display("tb_debounce_press_longpress_detector: done, clean");
        else
            $display("tb_debounce_press_longpress_detector: done, errors");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_debounce_press_longpress_detector: done, errors");
        $finish;
    end

endmodule
